@@ hdl/frame_bitmap_allocator_assert.svh @@
// Assertion macros shared by the frame bitmap allocator modules.
// Depends on nothing; included by the modules that check their own logic.
`ifndef FRAME_BITMAP_ALLOCATOR_ASSERT_SVH
`define FRAME_BITMAP_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define FBA_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define FBA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/fba_pkg.sv @@
// Shared types and constants of the frame bitmap allocator.
// No dependencies; used by every module of the block.
package fba_pkg;

    // Default geometry
    localparam int NUM_FRAMES_DEF  = 32768;
    localparam int FRAME_BYTES_DEF = 4096;

    // Bitmap word organization
    localparam int WORD_BITS = 32;
    localparam int BIT_W     = 5;

    // Action codes
    localparam logic [2:0] ACT_ALLOC    = 3'd0;
    localparam logic [2:0] ACT_FREE     = 3'd1;
    localparam logic [2:0] ACT_RESERVE  = 3'd2;
    localparam logic [2:0] ACT_RELEASE  = 3'd3;
    localparam logic [2:0] ACT_MARK_ALL = 3'd4;

    // Only this memory-map type is released
    localparam logic [31:0] REGION_USABLE = 32'd1;

    typedef struct packed {
        logic [2:0]  action;
        logic [63:0] base_addr;
        logic [31:0] limit_addr;
        logic [63:0] region_length;
        logic [31:0] region_type;
    } s_item_t;

    typedef struct packed {
        logic [31:0] frame_addr;
        logic        found;
    } m_item_t;

endpackage

@@ hdl/frame_bitmap_allocator.sv @@
// Frame bitmap allocator: one used bit per physical frame, kept in a single
// memory of 32-bit words (a 1024 x 32 array at the default 32768 frames).
// One beat in gives one beat out. After reset the block sweeps the bitmap to
// all used, one word a cycle, and takes no beat until the sweep is done.
// Allocate starts at the lowest word that may hold a free frame and steps
// over each full word before it hands off the result. Free, reserve and
// release walk each bitmap word the frame span covers through
// read-modify-write; mark-all-used sweeps the whole bitmap again. The
// memory has a single read port with registered read data. Requires
// fba_pkg, fba_ctrl, fba_map_ram.
`include "frame_bitmap_allocator_assert.svh"

module frame_bitmap_allocator #(
    parameter int NUM_FRAMES  = fba_pkg::NUM_FRAMES_DEF,
    parameter int FRAME_BYTES = fba_pkg::FRAME_BYTES_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  fba_pkg::s_item_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output fba_pkg::m_item_t m_data
);

    localparam int MAP_WORDS = (NUM_FRAMES + fba_pkg::WORD_BITS - 1) / fba_pkg::WORD_BITS;
    localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

    logic                          out_free;
    logic                          done;
    fba_pkg::m_item_t              result;
    logic                          mem_we;
    logic [ADDR_W-1:0]             mem_waddr;
    logic [fba_pkg::WORD_BITS-1:0] mem_wdata;
    logic                          mem_re;
    logic [ADDR_W-1:0]             mem_raddr;
    logic [fba_pkg::WORD_BITS-1:0] mem_rdata;
    logic                          m_valid_reg;
    fba_pkg::m_item_t              m_data_reg;

    assign out_free = !m_valid_reg || m_ready;

    fba_ctrl #(
        .NUM_FRAMES  (NUM_FRAMES),
        .FRAME_BYTES (FRAME_BYTES),
        .MAP_WORDS   (MAP_WORDS),
        .ADDR_W      (ADDR_W)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .out_free  (out_free),
        .done      (done),
        .result    (result),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    fba_map_ram #(
        .MAP_WORDS (MAP_WORDS),
        .ADDR_W    (ADDR_W)
    ) u_map_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Hold the result beat until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (done) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `FBA_ASSERT_NOW(a_push_into_free_slot, aclk, aresetn, done, out_free, "result pushed over a waiting beat")
    `FBA_ASSERT_NEXT(a_one_beat_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready, "second beat taken before the first finished")

endmodule

@@ hdl/fba_map_ram.sv @@
// Bitmap storage of the frame bitmap allocator: one write and one read port.
// Depends on fba_pkg for the word width.
module fba_map_ram #(
    parameter int MAP_WORDS = 1024,
    parameter int ADDR_W    = 10
) (
    input  logic                           aclk,
    input  logic                           we,
    input  logic [ADDR_W-1:0]              waddr,
    input  logic [fba_pkg::WORD_BITS-1:0]  wdata,
    input  logic                           re,
    input  logic [ADDR_W-1:0]              raddr,
    output logic [fba_pkg::WORD_BITS-1:0]  rdata
);

    logic [fba_pkg::WORD_BITS-1:0] mem [MAP_WORDS];
    logic [fba_pkg::WORD_BITS-1:0] rdata_reg;

    // Write one word, read one word with registered data
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/fba_zero_find.sv @@
// Lowest-zero-bit finder for one bitmap word.
// Depends on fba_pkg for the word and index widths.
module fba_zero_find (
    input  logic [fba_pkg::WORD_BITS-1:0] word,
    output logic                          any_zero,
    output logic [fba_pkg::BIT_W-1:0]     bit_idx
);

    // Scan from the top so the lowest zero wins
    always_comb begin
        bit_idx = '0;
        for (int i = fba_pkg::WORD_BITS - 1; i >= 0; i--) begin
            if (!word[i]) begin
                bit_idx = fba_pkg::BIT_W'(i);
            end
        end
    end

    assign any_zero = ~&word;

endmodule

@@ hdl/fba_ctrl.sv @@
// Sequencer of the frame bitmap allocator: decodes a beat, walks bitmap words
// through read-modify-write, scans for a free frame. Depends on fba_pkg,
// fba_zero_find and the assertion header.
`include "frame_bitmap_allocator_assert.svh"

module fba_ctrl #(
    parameter int NUM_FRAMES  = fba_pkg::NUM_FRAMES_DEF,
    parameter int FRAME_BYTES = fba_pkg::FRAME_BYTES_DEF,
    parameter int MAP_WORDS   = 1024,
    parameter int ADDR_W      = 10
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  fba_pkg::s_item_t              s_data,
    input  logic                          out_free,
    output logic                          done,
    output fba_pkg::m_item_t              result,
    output logic                          mem_we,
    output logic [ADDR_W-1:0]             mem_waddr,
    output logic [fba_pkg::WORD_BITS-1:0] mem_wdata,
    output logic                          mem_re,
    output logic [ADDR_W-1:0]             mem_raddr,
    input  logic [fba_pkg::WORD_BITS-1:0] mem_rdata
);

    localparam int FRAME_SHIFT = $clog2(FRAME_BYTES);
    localparam int HINT_W      = $clog2(MAP_WORDS + 1);
    localparam int FIDX_W      = $clog2(NUM_FRAMES + 1);
    localparam int FIRST_W     = 64 - FRAME_SHIFT;
    localparam int CNT_W       = FIRST_W + 1;
    localparam int WB          = fba_pkg::WORD_BITS;
    localparam int BW          = fba_pkg::BIT_W;

    typedef enum logic [8:0] {
        ST_SWEEP    = 9'b000000001,
        ST_IDLE     = 9'b000000010,
        ST_SETUP1   = 9'b000000100,
        ST_SETUP2   = 9'b000001000,
        ST_FILL     = 9'b000010000,
        ST_DRAIN    = 9'b000100000,
        ST_SCAN_RD  = 9'b001000000,
        ST_SCAN_CHK = 9'b010000000,
        ST_FINISH   = 9'b100000000
    } state_t;

    state_t                state_reg, state_next;
    logic                  set_reg, set_next;
    logic                  reply_reg, reply_next;
    logic [FIRST_W-1:0]    first_reg, first_next;
    logic [63:0]           len_reg, len_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [ADDR_W-1:0]     walk_reg, walk_next;
    logic [ADDR_W-1:0]     wlo_reg, wlo_next;
    logic [ADDR_W-1:0]     whi_reg, whi_next;
    logic [BW-1:0]         blo_reg, blo_next;
    logic [BW-1:0]         bhi_reg, bhi_next;
    logic                  pend_reg, pend_next;
    logic [ADDR_W-1:0]     pend_addr_reg, pend_addr_next;
    logic [HINT_W-1:0]     hint_reg, hint_next;
    fba_pkg::m_item_t      res_reg, res_next;

    logic                  first_ok;
    logic [FIDX_W-1:0]     room;
    logic [FIDX_W-1:0]     flo;
    logic [FIDX_W-1:0]     fhi;
    logic [FIDX_W-1:0]     last_x;
    logic [31:0]           rsv_start;
    logic [BW-1:0]         lo_bit;
    logic [BW-1:0]         hi_bit;
    logic [WB-1:0]         fill_mask;
    logic                  any_zero;
    logic [BW-1:0]         zero_bit;
    logic [63:0]           frame_idx;
    logic                  accept;

    fba_zero_find u_zero_find (
        .word     (mem_rdata),
        .any_zero (any_zero),
        .bit_idx  (zero_bit)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign rsv_start = s_data.base_addr[31:0];

    // Clip the frame span against the end of the bitmap
    assign first_ok = first_reg < FIRST_W'(NUM_FRAMES);
    assign room     = FIDX_W'(NUM_FRAMES) - FIDX_W'(first_reg);
    assign flo      = FIDX_W'(first_reg);
    assign last_x   = (count_reg > CNT_W'(room)) ? FIDX_W'(NUM_FRAMES)
                                                 : flo + FIDX_W'(count_reg);
    assign fhi      = last_x - FIDX_W'(1);

    // Bits of the pending word that fall inside the span
    assign lo_bit = (pend_addr_reg == wlo_reg) ? blo_reg : '0;
    assign hi_bit = (pend_addr_reg == whi_reg) ? bhi_reg : BW'(WB - 1);
    always_comb begin
        for (int b = 0; b < WB; b++) begin
            fill_mask[b] = (BW'(b) >= lo_bit) && (BW'(b) <= hi_bit);
        end
    end

    assign frame_idx = 64'({walk_reg, zero_bit});

    // Bitmap port: sweep, pending fill write-back, or allocate write-back
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = pend_addr_reg;
        mem_wdata = set_reg ? (mem_rdata | fill_mask) : (mem_rdata & ~fill_mask);
        mem_re    = 1'b0;
        mem_raddr = walk_reg;
        if (state_reg == ST_SWEEP) begin
            mem_we    = 1'b1;
            mem_waddr = walk_reg;
            mem_wdata = '1;
        end else if (pend_reg) begin
            mem_we = 1'b1;
        end else if (state_reg == ST_SCAN_CHK && any_zero) begin
            mem_we    = 1'b1;
            mem_waddr = walk_reg;
            mem_wdata = mem_rdata | (WB'(1) << zero_bit);
        end
        if (state_reg == ST_FILL || state_reg == ST_SCAN_RD) begin
            mem_re = 1'b1;
        end
    end

    // Sequence the actions
    always_comb begin
        state_next     = state_reg;
        set_next       = set_reg;
        reply_next     = reply_reg;
        first_next     = first_reg;
        len_next       = len_reg;
        count_next     = count_reg;
        walk_next      = walk_reg;
        wlo_next       = wlo_reg;
        whi_next       = whi_reg;
        blo_next       = blo_reg;
        bhi_next       = bhi_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        hint_next      = hint_reg;
        res_next       = res_reg;
        done           = 1'b0;

        unique case (state_reg)
            ST_SWEEP: begin
                walk_next = walk_reg + ADDR_W'(1);
                if (walk_reg == ADDR_W'(MAP_WORDS - 1)) begin
                    hint_next  = HINT_W'(MAP_WORDS);
                    state_next = reply_reg ? ST_FINISH : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    res_next = '0;
                    unique case (s_data.action)
                        fba_pkg::ACT_ALLOC: begin
                            walk_next  = ADDR_W'(hint_reg);
                            state_next = ST_SCAN_RD;
                        end
                        fba_pkg::ACT_FREE: begin
                            set_next   = 1'b0;
                            first_next = FIRST_W'(rsv_start[31:FRAME_SHIFT]);
                            len_next   = 64'(FRAME_BYTES);
                            state_next = ST_SETUP1;
                        end
                        fba_pkg::ACT_RESERVE: begin
                            set_next   = 1'b1;
                            first_next = FIRST_W'(rsv_start[31:FRAME_SHIFT]);
                            len_next   = (rsv_start < s_data.limit_addr)
                                       ? 64'(s_data.limit_addr - rsv_start) : '0;
                            state_next = ST_SETUP1;
                        end
                        fba_pkg::ACT_RELEASE: begin
                            set_next   = 1'b0;
                            first_next = s_data.base_addr[63:FRAME_SHIFT];
                            len_next   = (s_data.region_type == fba_pkg::REGION_USABLE)
                                       ? s_data.region_length : '0;
                            state_next = ST_SETUP1;
                        end
                        fba_pkg::ACT_MARK_ALL: begin
                            walk_next  = '0;
                            reply_next = 1'b1;
                            state_next = ST_SWEEP;
                        end
                        default: begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_SETUP1: begin
                // Round the byte length up to whole frames
                count_next = CNT_W'(len_reg[63:FRAME_SHIFT])
                           + CNT_W'(|len_reg[FRAME_SHIFT-1:0]);
                state_next = ST_SETUP2;
            end
            ST_SETUP2: begin
                if (first_ok && count_reg != '0) begin
                    wlo_next   = ADDR_W'(flo >> BW);
                    whi_next   = ADDR_W'(fhi >> BW);
                    blo_next   = BW'(flo);
                    bhi_next   = BW'(fhi);
                    walk_next  = ADDR_W'(flo >> BW);
                    state_next = ST_FILL;
                    if (!set_reg && HINT_W'(ADDR_W'(flo >> BW)) < hint_reg) begin
                        hint_next = HINT_W'(ADDR_W'(flo >> BW));
                    end
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_FILL: begin
                // Stream reads; each word is written back in the following cycle
                pend_next      = 1'b1;
                pend_addr_next = walk_reg;
                walk_next      = walk_reg + ADDR_W'(1);
                if (walk_reg == whi_reg) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_FINISH;
            end
            ST_SCAN_RD: begin
                if (hint_reg == HINT_W'(MAP_WORDS)) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_SCAN_CHK;
                end
            end
            ST_SCAN_CHK: begin
                if (any_zero) begin
                    res_next.found      = 1'b1;
                    res_next.frame_addr = 32'(frame_idx << FRAME_SHIFT);
                    state_next          = ST_FINISH;
                end else begin
                    // Word is full: nothing free below the next one
                    hint_next  = hint_reg + HINT_W'(1);
                    walk_next  = walk_reg + ADDR_W'(1);
                    state_next = ST_SCAN_RD;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    done       = 1'b1;
                    reply_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_SWEEP;
            walk_reg  <= '0;
            reply_reg <= 1'b0;
            pend_reg  <= 1'b0;
            hint_reg  <= HINT_W'(MAP_WORDS);
        end else begin
            state_reg <= state_next;
            walk_reg  <= walk_next;
            reply_reg <= reply_next;
            pend_reg  <= pend_next;
            hint_reg  <= hint_next;
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        set_reg       <= set_next;
        first_reg     <= first_next;
        len_reg       <= len_next;
        count_reg     <= count_next;
        wlo_reg       <= wlo_next;
        whi_reg       <= whi_next;
        blo_reg       <= blo_next;
        bhi_reg       <= bhi_next;
        pend_addr_reg <= pend_addr_next;
        res_reg       <= res_next;
    end

    assign result = res_reg;

    `FBA_ASSERT_NOW(a_no_rw_clash, aclk, aresetn, mem_we && mem_re,
        mem_waddr != mem_raddr, "bitmap read and write hit the same word")
    `FBA_ASSERT_NOW(a_pend_from_fill, aclk, aresetn, pend_reg,
        $past(state_reg) == ST_FILL, "write-back without a fill read")
    `FBA_ASSERT_NOW(a_hint_range, aclk, aresetn, 1'b1,
        hint_reg <= HINT_W'(MAP_WORDS), "scan hint beyond the bitmap")
    `FBA_ASSERT_NOW(a_walk_bound, aclk, aresetn, state_reg == ST_FILL,
        walk_reg <= whi_reg, "fill walked past its last word")

endmodule
